### src/mkcd_pkg.sv
package mkcd_pkg;

	localparam int NUM_KEYS_DEF = 4;
	localparam int NUM_PINS     = 4;
	localparam int KEY_IDX_W    = 2;
	localparam int NUM_SLOTS    = 1 << KEY_IDX_W;
	localparam int FLAG_W       = 7;
	localparam int SCAN_W       = 8;
	localparam int TMR_W        = 16;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;

	localparam int FL_HOLD_BIT   = 0;
	localparam int FL_DOWN_BIT   = 1;
	localparam int FL_UP_BIT     = 2;
	localparam int FL_SINGLE_BIT = 3;
	localparam int FL_DOUBLE_BIT = 4;
	localparam int FL_LONG_BIT   = 5;
	localparam int FL_REPEAT_BIT = 6;

	localparam logic [FLAG_W-1:0] FL_HOLD = 7'h01;

	localparam logic [SCAN_W-1:0] SCAN_PERIOD_RST   = 8'd20;
	localparam logic [TMR_W-1:0]  DOUBLE_WINDOW_RST = 16'd200;
	localparam logic [TMR_W-1:0]  LONG_TIME_RST     = 16'd2000;
	localparam logic [TMR_W-1:0]  REPEAT_PERIOD_RST = 16'd100;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SCAN_PERIOD   = 2'd0,
		CFG_DOUBLE_WINDOW = 2'd1,
		CFG_LONG_TIME     = 2'd2,
		CFG_REPEAT_PERIOD = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		CMD_TICK  = 1'b0,
		CMD_CHECK = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		KS_IDLE    = 3'd0,
		KS_PRESSED = 3'd1,
		KS_WAIT    = 3'd2,
		KS_SECOND  = 3'd3,
		KS_REPEAT  = 3'd4
	} key_state_t;

	typedef struct packed {
		logic [TMR_W-1:0] double_window;
		logic [TMR_W-1:0] long_time;
		logic [TMR_W-1:0] repeat_period;
	} key_cfg_t;

	typedef struct packed {
		logic              tick;
		logic              sample;
		logic              clr;
		logic [FLAG_W-1:0] clr_mask;
	} key_ctrl_t;

endpackage

### src/multi_key_click_detector.sv
// an accepted item passes through the input stage and then the result register
// throughput: one item per cycle, tick or check, with result_stall low
// item_stall rises only while a finished result is held by result_stall
// arst_n clears all key state, the scan counter and both pipeline stages
// and loads the register defaults (scan 20, double 200, long 2000, repeat 100)
module multi_key_click_detector #(
	parameter int NUM_KEYS = mkcd_pkg::NUM_KEYS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic                            cmd,
	input  logic [mkcd_pkg::NUM_PINS-1:0]   key_pins,
	input  logic [mkcd_pkg::KEY_IDX_W-1:0]  key_index,
	input  logic [mkcd_pkg::FLAG_W-1:0]     flag_mask,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic                            hit,
	output logic [mkcd_pkg::FLAG_W-1:0]     key_flags,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mkcd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mkcd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mkcd_pkg::*;

	logic                 valid_s1;
	logic                 cmd_s1;
	logic [NUM_PINS-1:0]  pins_s1;
	logic [KEY_IDX_W-1:0] idx_s1;
	logic [FLAG_W-1:0]    mask_s1;

	logic                 result_valid_q;
	logic                 hit_q;
	logic [FLAG_W-1:0]    key_flags_q;

	logic [SCAN_W-1:0]    scan_period_q;
	logic [SCAN_W-1:0]    scan_count_q;
	logic [SCAN_W-1:0]    scan_next;
	key_cfg_t             key_cfg_q;

	logic                 advance;
	logic                 tick_go;
	logic                 check_go;
	logic                 sample;
	logic                 check_hit;
	logic                 clr_ok;
	logic [FLAG_W-1:0]    sel_flags;
	logic [FLAG_W-1:0]    flags_k [NUM_KEYS];
	logic [FLAG_W-1:0]    slot_flags [NUM_SLOTS];

	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && result_valid_q && result_stall;
	assign tick_go    = advance && (cmd_s1 == CMD_TICK);
	assign check_go   = advance && (cmd_s1 == CMD_CHECK);
	assign cfg_ready  = 1'b1;

	assign scan_next = scan_count_q + 1'b1;
	assign sample    = (scan_next >= scan_period_q);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_period_q           <= SCAN_PERIOD_RST;
			key_cfg_q.double_window <= DOUBLE_WINDOW_RST;
			key_cfg_q.long_time     <= LONG_TIME_RST;
			key_cfg_q.repeat_period <= REPEAT_PERIOD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SCAN_PERIOD:   scan_period_q           <= cfg_data[SCAN_W-1:0];
				CFG_DOUBLE_WINDOW: key_cfg_q.double_window <= cfg_data[TMR_W-1:0];
				CFG_LONG_TIME:     key_cfg_q.long_time     <= cfg_data[TMR_W-1:0];
				CFG_REPEAT_PERIOD: key_cfg_q.repeat_period <= cfg_data[TMR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			cmd_s1  <= cmd;
			pins_s1 <= key_pins;
			idx_s1  <= key_index;
			mask_s1 <= flag_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_count_q <= '0;
		end else if (tick_go) begin
			scan_count_q <= sample ? '0 : scan_next;
		end
	end

	// per-key units
	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
		key_ctrl_t ctrl;
		logic      now;
		logic      sel;

		if (k < NUM_SLOTS) begin : g_idx
			assign sel = (idx_s1 == KEY_IDX_W'(k));
		end else begin : g_noidx
			assign sel = 1'b0;
		end

		if (k < NUM_PINS) begin : g_pin
			assign now = !pins_s1[k];
		end else begin : g_nopin
			assign now = 1'b0;
		end

		assign ctrl.tick     = tick_go;
		assign ctrl.sample   = sample;
		assign ctrl.clr      = check_go && sel && clr_ok;
		assign ctrl.clr_mask = mask_s1;

		mkcd_key u_key (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.now    (now),
			.cfg    (key_cfg_q),
			.flags  (flags_k[k])
		);
	end

	for (genvar s = 0; s < NUM_SLOTS; s++) begin : g_slot
		if (s < NUM_KEYS) begin : g_used
			assign slot_flags[s] = flags_k[s];
		end else begin : g_empty
			assign slot_flags[s] = '0;
		end
	end

	assign sel_flags = slot_flags[idx_s1];
	assign check_hit = |(sel_flags & mask_s1);
	assign clr_ok    = check_hit && (mask_s1 != FL_HOLD);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hit_q       <= check_go && check_hit;
			key_flags_q <= check_go ? sel_flags : '0;
		end
	end

	assign result_valid = result_valid_q;
	assign hit          = hit_q;
	assign key_flags    = key_flags_q;

endmodule

### src/mkcd_key.sv
module mkcd_key (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mkcd_pkg::key_ctrl_t        ctrl,
	input  logic                       now,
	input  mkcd_pkg::key_cfg_t         cfg,
	output logic [mkcd_pkg::FLAG_W-1:0] flags
);
	import mkcd_pkg::*;

	key_state_t        state_q, state_n;
	logic [TMR_W-1:0]  timer_q, timer_n, timer_dec;
	logic [FLAG_W-1:0] flags_q, flags_n;
	logic              pressed_q;

	assign timer_dec = (timer_q != '0) ? timer_q - 1'b1 : '0;
	assign flags     = flags_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= KS_IDLE;
			timer_q   <= '0;
			flags_q   <= '0;
			pressed_q <= 1'b0;
		end else begin
			state_q <= state_n;
			timer_q <= timer_n;
			flags_q <= flags_n;
			if (ctrl.tick && ctrl.sample) begin
				pressed_q <= now;
			end
		end
	end

	always_comb begin
		state_n = state_q;
		timer_n = timer_q;
		flags_n = flags_q;
		if (ctrl.tick) begin
			timer_n = timer_dec;
			if (ctrl.sample) begin
				flags_n[FL_HOLD_BIT] = now;
				if (now && !pressed_q) begin
					flags_n[FL_DOWN_BIT] = 1'b1;
				end
				if (!now && pressed_q) begin
					flags_n[FL_UP_BIT] = 1'b1;
				end
				case (state_q)
					KS_IDLE: begin
						if (now) begin
							timer_n = cfg.long_time;
							state_n = KS_PRESSED;
						end
					end
					KS_PRESSED: begin
						if (!now) begin
							timer_n = cfg.double_window;
							state_n = KS_WAIT;
						end else if (timer_dec == '0) begin
							timer_n                = cfg.repeat_period;
							flags_n[FL_LONG_BIT]   = 1'b1;
							state_n                = KS_REPEAT;
						end
					end
					KS_WAIT: begin
						if (now) begin
							flags_n[FL_DOUBLE_BIT] = 1'b1;
							state_n                = KS_SECOND;
						end else if (timer_dec == '0) begin
							flags_n[FL_SINGLE_BIT] = 1'b1;
							state_n                = KS_IDLE;
						end
					end
					KS_SECOND: begin
						if (!now) begin
							state_n = KS_IDLE;
						end
					end
					KS_REPEAT: begin
						if (!now) begin
							state_n = KS_IDLE;
						end else if (timer_dec == '0) begin
							timer_n                = cfg.repeat_period;
							flags_n[FL_REPEAT_BIT] = 1'b1;
						end
					end
					default: begin
						state_n = state_q;
					end
				endcase
			end
		end else if (ctrl.clr) begin
			flags_n = flags_q & ~ctrl.clr_mask;
		end
	end

endmodule

### src/mkcd_checker.sv
module mkcd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        item_valid,
	input logic                        item_stall,
	input logic                        result_valid,
	input logic                        result_stall,
	input logic                        hit,
	input logic [mkcd_pkg::FLAG_W-1:0] key_flags
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(hit) && $stable(key_flags))
		else $error("stalled result changed");

	a_hit_flags: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && hit |-> key_flags != '0)
		else $error("hit without flags");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("item stalled while result side free");

	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_valid && !item_stall, 2))
		else $error("result without accepted item");

endmodule

bind multi_key_click_detector mkcd_checker u_mkcd_checker (.*);
